// ===== hdl/rrsps_pkg.sv =====
// ----------------------------------------------------------------------------
// rrsps_pkg
// Shared constants, field layout and helpers for the round-robin sensor
// poll sequencer and its checker.
// ----------------------------------------------------------------------------
package rrsps_pkg;

    // channel layout: ambient, thermocouples, thermistors
    localparam int TC_CHANNELS = 4;
    localparam int TH_CHANNELS = 2;
    localparam int NCH         = 1 + TC_CHANNELS + TH_CHANNELS;
    localparam int MAX_REPORT  = 7;
    localparam int NREP        = (NCH < MAX_REPORT) ? NCH : MAX_REPORT;

    // field widths
    localparam int CH_W    = 3;
    localparam int WORD_W  = 16;
    localparam int TEMP_W  = 24;
    localparam int TIME_W  = 64;
    localparam int MS_W    = 16;
    localparam int US_W    = 26;
    localparam int MASK_W  = 6;
    localparam int SUM_W   = TEMP_W + 1;
    localparam int PROD_W  = SUM_W + TEMP_W;

    // stream widths
    localparam int IN_W  = 96;
    localparam int OUT_W = 32;

    // input tdata layout
    localparam int I_NOW_LSB  = 0;
    localparam int I_ADC_BIT  = 64;
    localparam int I_TEMP_LSB = 65;

    // output tdata layout
    localparam int O_CH_LSB   = 0;
    localparam int O_VAL_LSB  = 3;
    localparam int O_RD_BIT   = 19;
    localparam int O_SV_BIT   = 20;
    localparam int O_SC_LSB   = 21;
    localparam int O_WM_BIT   = 24;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_PERIOD   = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_OFFSET   = 3'd2;
    localparam logic [2:0] REG_SCALE    = 3'd3;
    localparam logic [2:0] REG_AMB_CONV = 3'd4;
    localparam logic [2:0] REG_TC_CONV  = 3'd5;

    // reset and limit values
    localparam logic [MS_W-1:0]   PERIOD_RST = 16'd5000;
    localparam logic [MS_W-1:0]   PERIOD_MIN = 16'd500;
    localparam logic [MASK_W-1:0] MASK_RST   = 6'd63;
    localparam logic [TEMP_W-1:0] SCALE_RST  = 24'd25600;
    localparam logic [MS_W-1:0]   CONV_DFLT  = 16'd250;
    localparam logic [WORD_W-1:0] WORD_RST   = 16'hFFFF;
    localparam logic [CH_W-1:0]   CH_RST     = 3'd7;

    // one item waiting in the multiply stage
    typedef struct packed {
        logic                    rd;
        logic [CH_W-1:0]         ch;
        logic signed [SUM_W-1:0] sum;
        logic                    we;
        logic                    started;
        logic [CH_W-1:0]         st_ch;
        logic                    wait_adc;
        logic                    report;
    } s1_t;

    // milliseconds to microseconds
    function automatic logic [US_W-1:0] ms_to_us(input logic [MS_W-1:0] ms);
        ms_to_us = US_W'(ms) * US_W'(1000);
    endfunction

    // conversion delay, zero means the default
    function automatic logic [US_W-1:0] conv_us(input logic [MS_W-1:0] ms);
        logic [MS_W-1:0] d;
        d = (ms == '0) ? CONV_DFLT : ms;
        conv_us = ms_to_us(d);
    endfunction

    // output tdata packing
    function automatic logic [OUT_W-1:0] pack_out(
        input logic [CH_W-1:0]   ch,
        input logic [WORD_W-1:0] val,
        input logic              rd,
        input logic              sv,
        input logic [CH_W-1:0]   sc,
        input logic              wm
    );
        pack_out = {7'd0, wm, sc, sv, rd, val, ch};
    endfunction

endpackage

// ===== hdl/round_robin_sensor_poll_sequencer.sv =====
// ----------------------------------------------------------------------------
// round_robin_sensor_poll_sequencer
// Poll-driven sequencer: waits on a deadline or the ADC, converts and stores
// the reading, starts the next enabled channel and emits periodic reports.
// ----------------------------------------------------------------------------
// A poll updates the sequencer on accept, fills the multiply stage, and its
// scaled status result then enters the output register. Throughput: one poll
// per cycle while no report runs and m_* is not stalled; a report run sends
// NREP entries, each a word RAM read, then the output register; one more
// poll enters the multiply stage meanwhile and waits for the final entry.
// Reset: registers return to their defaults, the sequencer selects the next
// channel, and stored words read as 0xFFFF through per-entry valid bits.
module round_robin_sensor_poll_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    // poll input: now_us[63:0], adc_done[64], sample_temp[88:65]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rrsps_pkg::IN_W-1:0]    s_tdata,
    // results: channel[2:0], value[18:3], read_done[19], started_valid[20],
    // started_channel[23:21], wait_mode[24]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rrsps_pkg::OUT_W-1:0]   m_tdata,
    // is_report[0]
    output logic                          m_tuser,
    output logic                          m_tlast,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rrsps_pkg::ADDR_W-1:0]  paddr,
    input  logic [rrsps_pkg::DATA_W-1:0]  pwdata,
    output logic [rrsps_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam logic [1:0] PH_NEXT       = 2'd0;
    localparam logic [1:0] PH_WAIT_CLOCK = 2'd1;
    localparam logic [1:0] PH_WAIT_ADC   = 2'd2;

    localparam int CH_W   = rrsps_pkg::CH_W;
    localparam int RAM_AW = $clog2(rrsps_pkg::NCH);

    // configuration registers
    logic [rrsps_pkg::MS_W-1:0]   period_ms_reg;
    logic [rrsps_pkg::MASK_W-1:0] mask_reg;
    logic [rrsps_pkg::TEMP_W-1:0] offset_reg;
    logic [rrsps_pkg::TEMP_W-1:0] scale_reg;
    logic [rrsps_pkg::MS_W-1:0]   amb_ms_reg;
    logic [rrsps_pkg::MS_W-1:0]   tc_ms_reg;
    logic [rrsps_pkg::US_W-1:0]   period_us_reg;
    logic [rrsps_pkg::US_W-1:0]   amb_us_reg;
    logic [rrsps_pkg::US_W-1:0]   tc_us_reg;

    logic                         cfg_wr;
    logic [2:0]                   cfg_idx;
    logic [rrsps_pkg::MS_W-1:0]   wr_ms;
    logic [rrsps_pkg::MS_W-1:0]   wr_period;
    logic [rrsps_pkg::MS_W-1:0]   tc_max_amb;
    logic [rrsps_pkg::MS_W-1:0]   tc_max_tc;

    // sequencer state
    logic [1:0]                   phase_reg;
    logic [CH_W-1:0]              cur_reg;
    logic [rrsps_pkg::TIME_W-1:0] deadline_reg;
    logic [rrsps_pkg::TIME_W-1:0] next_rep_reg;

    // multiply stage
    logic                         s1_valid_reg;
    rrsps_pkg::s1_t               s1_reg;
    rrsps_pkg::s1_t               s1_next;
    logic                         s1_go;

    // report run
    logic                         rep_active_reg;
    logic [RAM_AW-1:0]            rep_idx_reg;
    logic                         rd_pend_reg;
    logic                         rd_vld_reg;
    logic                         rep_busy;
    logic                         rep_issue;
    logic                         rep_deliver;
    logic [rrsps_pkg::NCH-1:0]    words_vld_reg;
    logic [rrsps_pkg::WORD_W-1:0] ram_rdata;
    logic [rrsps_pkg::WORD_W-1:0] rep_word;

    // output register
    logic                         out_valid_reg;
    logic [rrsps_pkg::OUT_W-1:0]  out_data_reg;
    logic                         out_user_reg;
    logic                         out_last_reg;
    logic                         out_free;

    // poll decode
    logic                         accept;
    logic [rrsps_pkg::TIME_W-1:0] now_us;
    logic                         adc_done;
    logic [rrsps_pkg::TEMP_W-1:0] sample_temp;
    logic                         do_read;
    logic                         do_start;
    logic [CH_W-1:0]              nxt_ch;
    logic                         nxt_found;
    logic [rrsps_pkg::US_W-1:0]   delay_us;
    logic                         rd_enabled;
    logic                         rep_due;

    // conversion
    logic signed [rrsps_pkg::PROD_W-1:0] prod;
    logic [rrsps_pkg::WORD_W-1:0]        conv_word;
    logic [rrsps_pkg::WORD_W-1:0]        st_word;

    assign pready = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    // channel k is polled when enabled; ambient always is
    function automatic logic chan_on(
        input logic [rrsps_pkg::MASK_W-1:0] mask,
        input logic [CH_W-1:0]              k
    );
        logic [(1 << CH_W)-1:0] en;
        en = '0;
        en[rrsps_pkg::MASK_W:0] = {mask | {rrsps_pkg::MASK_W{mask == '0}}, 1'b1};
        chan_on = en[k];
    endfunction

    // derived delay values on configuration writes
    always_comb
    begin
        wr_ms      = pwdata[rrsps_pkg::MS_W-1:0];
        wr_period  = (wr_ms < rrsps_pkg::PERIOD_MIN) ? rrsps_pkg::PERIOD_MIN : wr_ms;
        tc_max_amb = (tc_ms_reg > wr_ms) ? tc_ms_reg : wr_ms;
        tc_max_tc  = (wr_ms > amb_ms_reg) ? wr_ms : amb_ms_reg;
    end

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_ms_reg <= rrsps_pkg::PERIOD_RST;
            mask_reg      <= rrsps_pkg::MASK_RST;
            offset_reg    <= '0;
            scale_reg     <= rrsps_pkg::SCALE_RST;
            amb_ms_reg    <= '0;
            tc_ms_reg     <= '0;
            period_us_reg <= rrsps_pkg::ms_to_us(rrsps_pkg::PERIOD_RST);
            amb_us_reg    <= rrsps_pkg::conv_us('0);
            tc_us_reg     <= rrsps_pkg::conv_us('0);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                rrsps_pkg::REG_PERIOD:
                begin
                    period_ms_reg <= wr_period;
                    period_us_reg <= rrsps_pkg::ms_to_us(wr_period);
                end
                rrsps_pkg::REG_MASK:
                begin
                    mask_reg <= pwdata[rrsps_pkg::MASK_W-1:0];
                end
                rrsps_pkg::REG_OFFSET:
                begin
                    offset_reg <= pwdata[rrsps_pkg::TEMP_W-1:0];
                end
                rrsps_pkg::REG_SCALE:
                begin
                    scale_reg <= pwdata[rrsps_pkg::TEMP_W-1:0];
                end
                rrsps_pkg::REG_AMB_CONV:
                begin
                    amb_ms_reg <= wr_ms;
                    amb_us_reg <= rrsps_pkg::conv_us(wr_ms);
                    tc_us_reg  <= rrsps_pkg::conv_us(tc_max_amb);
                end
                rrsps_pkg::REG_TC_CONV:
                begin
                    tc_ms_reg <= wr_ms;
                    tc_us_reg <= rrsps_pkg::conv_us(tc_max_tc);
                end
                default:
                begin
                end
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            rrsps_pkg::REG_PERIOD:   prdata = rrsps_pkg::DATA_W'(period_ms_reg);
            rrsps_pkg::REG_MASK:     prdata = rrsps_pkg::DATA_W'(mask_reg);
            rrsps_pkg::REG_OFFSET:   prdata = rrsps_pkg::DATA_W'(offset_reg);
            rrsps_pkg::REG_SCALE:    prdata = rrsps_pkg::DATA_W'(scale_reg);
            rrsps_pkg::REG_AMB_CONV: prdata = rrsps_pkg::DATA_W'(amb_ms_reg);
            rrsps_pkg::REG_TC_CONV:  prdata = rrsps_pkg::DATA_W'(tc_ms_reg);
            default:                 prdata = '0;
        endcase
    end

    // handshake
    assign out_free  = !out_valid_reg || m_tready;
    assign rep_busy  = rep_active_reg || rd_pend_reg;
    assign s1_go     = s1_valid_reg && out_free && !rep_busy;
    assign s_tready  = !s1_valid_reg || s1_go;
    assign accept    = s_tvalid && s_tready;

    assign now_us      = s_tdata[rrsps_pkg::I_NOW_LSB +: rrsps_pkg::TIME_W];
    assign adc_done    = s_tdata[rrsps_pkg::I_ADC_BIT];
    assign sample_temp = s_tdata[rrsps_pkg::I_TEMP_LSB +: rrsps_pkg::TEMP_W];

    // read decision and next channel
    always_comb
    begin
        case (phase_reg)
            PH_WAIT_CLOCK: do_read = (now_us >= deadline_reg);
            PH_WAIT_ADC:   do_read = adc_done;
            default:       do_read = 1'b0;
        endcase
        do_start = do_read || (phase_reg == PH_NEXT);

        nxt_ch    = '0;
        nxt_found = 1'b0;
        for (int k = 1; k < rrsps_pkg::NCH; k++)
        begin
            if (!nxt_found && (CH_W'(k) > cur_reg) && chan_on(mask_reg, CH_W'(k)))
            begin
                nxt_ch    = CH_W'(k);
                nxt_found = 1'b1;
            end
        end

        delay_us   = (nxt_ch == '0) ? amb_us_reg : tc_us_reg;
        rd_enabled = chan_on(mask_reg, cur_reg);
        rep_due    = do_read && (now_us >= next_rep_reg);
    end

    // stage contents for the multiply cycle
    always_comb
    begin
        s1_next.rd       = do_read;
        s1_next.ch       = do_read ? cur_reg : '0;
        s1_next.sum      = $signed({sample_temp[rrsps_pkg::TEMP_W-1], sample_temp}) +
                           $signed({offset_reg[rrsps_pkg::TEMP_W-1], offset_reg});
        s1_next.we       = do_read && rd_enabled;
        s1_next.started  = do_start;
        s1_next.st_ch    = do_start ? nxt_ch : '0;
        s1_next.wait_adc = do_start ? (nxt_ch > CH_W'(rrsps_pkg::TC_CHANNELS))
                                    : (phase_reg == PH_WAIT_ADC);
        s1_next.report   = rep_due;
    end

    // sequencer update on each poll transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_NEXT;
            cur_reg      <= rrsps_pkg::CH_RST;
            deadline_reg <= '0;
            next_rep_reg <= '0;
        end
        else if (accept)
        begin
            if (do_start)
            begin
                cur_reg <= nxt_ch;
                if (nxt_ch <= CH_W'(rrsps_pkg::TC_CHANNELS))
                begin
                    deadline_reg <= now_us + rrsps_pkg::TIME_W'(delay_us);
                    phase_reg    <= PH_WAIT_CLOCK;
                end
                else
                begin
                    phase_reg <= PH_WAIT_ADC;
                end
            end
            if (rep_due)
            begin
                next_rep_reg <= now_us + rrsps_pkg::TIME_W'(period_us_reg);
            end
        end
    end

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    // scale and clamp to 0..65535
    always_comb
    begin
        prod = s1_reg.sum * $signed({1'b0, scale_reg});
        if (prod[rrsps_pkg::PROD_W-1])
        begin
            conv_word = '0;
        end
        else if (|prod[rrsps_pkg::PROD_W-2:32])
        begin
            conv_word = rrsps_pkg::WORD_RST;
        end
        else
        begin
            conv_word = prod[31:16];
        end
        st_word = s1_reg.rd ? conv_word : '0;
    end

    // stored words
    rrsps_ram #(
        .WIDTH (rrsps_pkg::WORD_W),
        .DEPTH (rrsps_pkg::NCH)
    ) u_words (
        .clk   (clk),
        .we    (s1_go && s1_reg.we),
        .waddr (RAM_AW'(s1_reg.ch)),
        .wdata (conv_word),
        .re    (rep_issue),
        .raddr (rep_idx_reg),
        .rdata (ram_rdata)
    );

    // per-entry valid bits, cleared by reset and by a mask write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_vld_reg <= '0;
        end
        else if (cfg_wr && (cfg_idx == rrsps_pkg::REG_MASK))
        begin
            words_vld_reg <= '0;
        end
        else if (s1_go && s1_reg.we)
        begin
            words_vld_reg[RAM_AW'(s1_reg.ch)] <= 1'b1;
        end
    end

    // report run: one RAM read, then one output transfer per entry
    assign rep_issue   = rep_active_reg && !rd_pend_reg;
    assign rep_deliver = rd_pend_reg && out_free;
    assign rep_word    = rd_vld_reg ? ram_rdata : rrsps_pkg::WORD_RST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_active_reg <= 1'b0;
            rep_idx_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            rd_vld_reg     <= 1'b0;
        end
        else
        begin
            if (s1_go && s1_reg.report)
            begin
                rep_active_reg <= 1'b1;
                rep_idx_reg    <= '0;
            end
            if (rep_issue)
            begin
                rd_pend_reg <= 1'b1;
                rd_vld_reg  <= words_vld_reg[rep_idx_reg];
            end
            if (rep_deliver)
            begin
                rd_pend_reg <= 1'b0;
                if (rep_idx_reg == RAM_AW'(rrsps_pkg::NREP - 1))
                begin
                    rep_active_reg <= 1'b0;
                end
                else
                begin
                    rep_idx_reg <= rep_idx_reg + RAM_AW'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go || rep_deliver)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_data_reg <= rrsps_pkg::pack_out(s1_reg.ch, st_word, s1_reg.rd,
                                                s1_reg.started, s1_reg.st_ch,
                                                s1_reg.wait_adc);
            out_user_reg <= 1'b0;
            out_last_reg <= !s1_reg.report;
        end
        else if (rep_deliver)
        begin
            out_data_reg <= rrsps_pkg::pack_out(CH_W'(rep_idx_reg), rep_word, 1'b0,
                                                1'b0, '0, 1'b0);
            out_user_reg <= 1'b1;
            out_last_reg <= (rep_idx_reg == RAM_AW'(rrsps_pkg::NREP - 1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/rrsps_ram.sv =====
// ----------------------------------------------------------------------------
// rrsps_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrsps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds while idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rrsps_chk.sv =====
// ----------------------------------------------------------------------------
// rrsps_chk
// Port-level checks on the result stream of the poll sequencer.
// ----------------------------------------------------------------------------
module rrsps_chk (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [rrsps_pkg::OUT_W-1:0] m_tdata,
    input  logic                        m_tuser,
    input  logic                        m_tlast
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // report entries carry no status flags
    a_rep_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            !m_tdata[rrsps_pkg::O_RD_BIT] && !m_tdata[rrsps_pkg::O_SV_BIT] &&
            !m_tdata[rrsps_pkg::O_WM_BIT] &&
            (m_tdata[rrsps_pkg::O_SC_LSB +: rrsps_pkg::CH_W] == '0))
        else $error("report entry with status flags set");

    // status without a read shows zero channel and value
    a_noread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && !m_tdata[rrsps_pkg::O_RD_BIT] |->
            (m_tdata[rrsps_pkg::O_CH_LSB +: rrsps_pkg::CH_W] == '0) &&
            (m_tdata[rrsps_pkg::O_VAL_LSB +: rrsps_pkg::WORD_W] == '0))
        else $error("status without read carries data");

    // a report run ends on its highest channel
    a_rep_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && m_tlast |->
            (m_tdata[rrsps_pkg::O_CH_LSB +: rrsps_pkg::CH_W] ==
             rrsps_pkg::CH_W'(rrsps_pkg::NREP - 1)))
        else $error("report run ended early");

endmodule

bind round_robin_sensor_poll_sequencer rrsps_chk u_rrsps_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
